// ===== hdl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Shape fill rasterizer package
// Shared constants, command and job codes, and the job record that passes
// from the command front end through the job queue to the fill engine.
// ----------------------------------------------------------------------------
package sfr_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;

    localparam int CMD_W     = 3;
    localparam int XY_W      = 9;
    localparam int SIZE_W    = 7;
    localparam int SYM_W     = 8;
    localparam int CNT_W     = 13;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    localparam int COUNT_MAX = (2 ** CNT_W) - 1;

    localparam int COL_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int GRID_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int D_W    = (((GRID_W + 1) > XY_W) ? (GRID_W + 1) : XY_W) + 1;
    localparam int SQ_W   = 2 * SIZE_W;
    localparam int AREA_W = COL_W + ROW_W;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] CANVAS_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'd1;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RECT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TRI    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CIRCLE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] JOB_NONE   = 3'd0;
    localparam logic [KIND_W-1:0] JOB_CLEAR  = 3'd1;
    localparam logic [KIND_W-1:0] JOB_RECT   = 3'd2;
    localparam logic [KIND_W-1:0] JOB_TRI    = 3'd3;
    localparam logic [KIND_W-1:0] JOB_CIRCLE = 3'd4;
    localparam logic [KIND_W-1:0] JOB_READ   = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [SIZE_W-1:0]       a;
        logic [SIZE_W-1:0]       b;
        logic [SYM_W-1:0]        sym;
        logic [COL_W-1:0]        w;
        logic [ROW_W-1:0]        h;
        logic [SQ_W-1:0]         asq;
        logic [CNT_W-1:0]        area;
        logic                    rd_out;
        logic [ADDR_W-1:0]       rd_addr;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ===== hdl/sfr_cmd_if.sv =====
// ----------------------------------------------------------------------------
// Shape fill rasterizer command channel
// Valid/ready channel that carries one drawing or read command per beat.
// ----------------------------------------------------------------------------
interface sfr_cmd_if;
    logic                            valid;
    logic                            ready;
    logic [sfr_pkg::CMD_W-1:0]       cmd;
    logic signed [sfr_pkg::XY_W-1:0] x_origin;
    logic signed [sfr_pkg::XY_W-1:0] y_origin;
    logic [sfr_pkg::SIZE_W-1:0]      size_a;
    logic [sfr_pkg::SIZE_W-1:0]      size_b;
    logic [sfr_pkg::SYM_W-1:0]       symbol;

    modport source (
        output valid, cmd, x_origin, y_origin, size_a, size_b, symbol,
        input  ready
    );

    modport sink (
        input  valid, cmd, x_origin, y_origin, size_a, size_b, symbol,
        output ready
    );
endinterface

// ===== hdl/sfr_res_if.sv =====
// ----------------------------------------------------------------------------
// Shape fill rasterizer result channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
interface sfr_res_if;
    logic                        valid;
    logic                        ready;
    logic [sfr_pkg::SYM_W-1:0]   cell_symbol;
    logic [sfr_pkg::CNT_W-1:0]   cells_written;
    logic                        outside;

    modport source (
        output valid, cell_symbol, cells_written, outside,
        input  ready
    );

    modport sink (
        input  valid, cell_symbol, cells_written, outside,
        output ready
    );
endinterface

// ===== hdl/sfr_front.sv =====
// ----------------------------------------------------------------------------
// Shape fill rasterizer front end
// Holds the canvas registers, accepts commands and classifies each one into
// a job record with clipped canvas size, squared radius and read address.
// ----------------------------------------------------------------------------
module sfr_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    sfr_cmd_if.sink                           i_cmd,
    input  logic                              i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [sfr_pkg::CFG_W-1:0]         i_cfg_data,
    input  sfr_pkg::t_q_status                i_q,
    output logic                              o_push,
    output sfr_pkg::t_job                     o_job
);

    logic [sfr_pkg::CFG_W-1:0]  r_canvas_w;
    logic [sfr_pkg::CFG_W-1:0]  r_canvas_h;
    logic [sfr_pkg::COL_W-1:0]  w_use;
    logic [sfr_pkg::ROW_W-1:0]  h_use;
    logic [sfr_pkg::AREA_W-1:0] area_full;
    logic                       empty_canvas;
    logic                       x_out;
    logic                       y_out;
    logic [sfr_pkg::XY_W-2:0]   x_mag;
    logic [sfr_pkg::XY_W-2:0]   y_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas_w <= sfr_pkg::CANVAS_RESET;
            r_canvas_h <= sfr_pkg::CANVAS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfr_pkg::REG_CANVAS_WIDTH: begin
                    r_canvas_w <= i_cfg_data;
                end
                sfr_pkg::REG_CANVAS_HEIGHT: begin
                    r_canvas_h <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w_use = (int'(r_canvas_w) > sfr_pkg::MAX_WIDTH) ?
                sfr_pkg::COL_W'(sfr_pkg::MAX_WIDTH) : sfr_pkg::COL_W'(r_canvas_w);
        h_use = (int'(r_canvas_h) > sfr_pkg::MAX_HEIGHT) ?
                sfr_pkg::ROW_W'(sfr_pkg::MAX_HEIGHT) : sfr_pkg::ROW_W'(r_canvas_h);
        area_full = sfr_pkg::AREA_W'(w_use) * sfr_pkg::AREA_W'(h_use);
        empty_canvas = (w_use == '0) || (h_use == '0);

        x_mag = i_cmd.x_origin[sfr_pkg::XY_W-2:0];
        y_mag = i_cmd.y_origin[sfr_pkg::XY_W-2:0];
        x_out = i_cmd.x_origin[sfr_pkg::XY_W-1] ||
                ({1'b0, x_mag} >= sfr_pkg::XY_W'(w_use));
        y_out = i_cmd.y_origin[sfr_pkg::XY_W-1] ||
                ({1'b0, y_mag} >= sfr_pkg::XY_W'(h_use));

        o_job.x       = i_cmd.x_origin;
        o_job.y       = i_cmd.y_origin;
        o_job.a       = i_cmd.size_a;
        o_job.b       = i_cmd.size_b;
        o_job.sym     = i_cmd.symbol;
        o_job.w       = w_use;
        o_job.h       = h_use;
        o_job.asq     = sfr_pkg::SQ_W'(i_cmd.size_a) * sfr_pkg::SQ_W'(i_cmd.size_a);
        o_job.area    = (int'(area_full) > sfr_pkg::COUNT_MAX) ?
                        sfr_pkg::CNT_W'(sfr_pkg::COUNT_MAX) : sfr_pkg::CNT_W'(area_full);
        o_job.rd_out  = x_out || y_out;
        o_job.rd_addr = sfr_pkg::ADDR_W'(int'(y_mag) * sfr_pkg::MAX_WIDTH + int'(x_mag));

        case (i_cmd.cmd)
            sfr_pkg::CMD_CLEAR: begin
                o_job.kind = sfr_pkg::JOB_CLEAR;
            end
            sfr_pkg::CMD_RECT: begin
                o_job.kind = empty_canvas ? sfr_pkg::JOB_NONE : sfr_pkg::JOB_RECT;
            end
            sfr_pkg::CMD_TRI: begin
                o_job.kind = empty_canvas ? sfr_pkg::JOB_NONE : sfr_pkg::JOB_TRI;
            end
            sfr_pkg::CMD_CIRCLE: begin
                o_job.kind = empty_canvas ? sfr_pkg::JOB_NONE : sfr_pkg::JOB_CIRCLE;
            end
            sfr_pkg::CMD_READ: begin
                o_job.kind = sfr_pkg::JOB_READ;
            end
            default: begin
                o_job.kind = sfr_pkg::JOB_NONE;
            end
        endcase
    end

    assign i_cmd.ready = !i_q.full;
    assign o_push      = i_cmd.valid && !i_q.full;

endmodule

// ===== hdl/sfr_queue.sv =====
// ----------------------------------------------------------------------------
// Shape fill rasterizer job queue
// Short FIFO of classified jobs between the front end and the fill engine.
// ----------------------------------------------------------------------------
module sfr_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  sfr_pkg::t_job      i_job,
    input  logic               i_pop,
    output sfr_pkg::t_job      o_job,
    output sfr_pkg::t_q_status o_status
);

    sfr_pkg::t_job              r_mem [sfr_pkg::QUEUE_DEPTH];
    logic [sfr_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [sfr_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [sfr_pkg::QCNT_W-1:0] r_count;
    logic                       do_push;
    logic                       do_pop;

    assign o_status.full  = (r_count == sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == sfr_pkg::QPTR_W'(sfr_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == sfr_pkg::QPTR_W'(sfr_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/sfr_engine.sv =====
// ----------------------------------------------------------------------------
// Shape fill rasterizer fill engine
// Owns the frame store. Sweeps the store for a clear or the canvas for a
// shape, one cell per cycle through a two-stage coverage test, performs
// cell reads and holds the result in an output register.
// ----------------------------------------------------------------------------
module sfr_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sfr_pkg::t_job      i_job,
    input  sfr_pkg::t_q_status i_q,
    output logic               o_pop,
    output logic               o_busy,
    sfr_res_if.source          o_res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FILL  = 3'd1;
    localparam logic [2:0] ST_SWEEP = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [sfr_pkg::SYM_W-1:0]  r_store [sfr_pkg::DEPTH];
    logic [sfr_pkg::SYM_W-1:0]  r_rd_data;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    sfr_pkg::t_job              r_job;
    logic [sfr_pkg::COL_W-1:0]  r_col;
    logic [sfr_pkg::ROW_W-1:0]  r_row;
    logic [sfr_pkg::ADDR_W-1:0] r_addr;
    logic [sfr_pkg::ADDR_W-1:0] r_row_base;
    logic [sfr_pkg::CNT_W-1:0]  r_count;

    logic                       r_s1_valid;
    logic [sfr_pkg::ADDR_W-1:0] r_s1_addr;
    logic                       r_s1_hit;
    logic                       r_s1_circ;
    logic [sfr_pkg::SQ_W-1:0]   r_s1_sqx;
    logic [sfr_pkg::SQ_W-1:0]   r_s1_sqy;

    logic                       r_res_valid;
    logic [sfr_pkg::SYM_W-1:0]  r_res_cell;
    logic [sfr_pkg::CNT_W-1:0]  r_res_count;
    logic                       r_res_out;

    logic signed [sfr_pkg::D_W-1:0] dx;
    logic signed [sfr_pkg::D_W-1:0] dy;
    logic signed [sfr_pkg::D_W-1:0] a_s;
    logic signed [sfr_pkg::D_W-1:0] b_s;
    logic [sfr_pkg::D_W-1:0]        mag_x;
    logic [sfr_pkg::D_W-1:0]        mag_y;
    logic                           rect_hit;
    logic                           shape_hit;
    logic                           circ_box;
    logic [sfr_pkg::SQ_W:0]         sq_sum;
    logic                           s2_write;
    logic                           wr_en;
    logic [sfr_pkg::ADDR_W-1:0]     wr_addr;
    logic                           last_col;
    logic                           last_row;

    always_comb begin
        dx    = sfr_pkg::D_W'($signed({1'b0, r_col})) - sfr_pkg::D_W'(r_job.x);
        dy    = sfr_pkg::D_W'($signed({1'b0, r_row})) - sfr_pkg::D_W'(r_job.y);
        a_s   = $signed(sfr_pkg::D_W'(r_job.a));
        b_s   = $signed(sfr_pkg::D_W'(r_job.b));
        mag_x = dx[sfr_pkg::D_W-1] ? sfr_pkg::D_W'(-dx) : sfr_pkg::D_W'(dx);
        mag_y = dy[sfr_pkg::D_W-1] ? sfr_pkg::D_W'(-dy) : sfr_pkg::D_W'(dy);

        rect_hit  = (dx >= 0) && (dx < a_s) && (dy >= 0) && (dy < b_s);
        shape_hit = ((r_job.kind == sfr_pkg::JOB_RECT) && rect_hit) ||
                    ((r_job.kind == sfr_pkg::JOB_TRI) && rect_hit && (dx <= dy));
        circ_box  = (r_job.kind == sfr_pkg::JOB_CIRCLE) &&
                    (dx >= -a_s) && (dx <= a_s) && (dy >= -a_s) && (dy <= a_s);

        sq_sum   = {1'b0, r_s1_sqx} + {1'b0, r_s1_sqy};
        s2_write = r_s1_valid && (r_s1_hit || (r_s1_circ && (sq_sum <= {1'b0, r_job.asq})));
        wr_en    = (r_state == ST_FILL) || s2_write;
        wr_addr  = (r_state == ST_FILL) ? r_addr : r_s1_addr;

        last_col = (r_col == r_job.w - sfr_pkg::COL_W'(1));
        last_row = (r_row == r_job.h - sfr_pkg::ROW_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[wr_addr] <= r_job.sym;
        end
        r_rd_data <= r_store[r_job.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= r_addr;
        r_s1_hit  <= shape_hit;
        r_s1_circ <= circ_box;
        r_s1_sqx  <= sfr_pkg::SQ_W'(mag_x[sfr_pkg::SIZE_W-1:0]) *
                     sfr_pkg::SQ_W'(mag_x[sfr_pkg::SIZE_W-1:0]);
        r_s1_sqy  <= sfr_pkg::SQ_W'(mag_y[sfr_pkg::SIZE_W-1:0]) *
                     sfr_pkg::SQ_W'(mag_y[sfr_pkg::SIZE_W-1:0]);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_pop) begin
                    case (i_job.kind)
                        sfr_pkg::JOB_CLEAR: begin
                            n_state = ST_FILL;
                        end
                        sfr_pkg::JOB_RECT, sfr_pkg::JOB_TRI, sfr_pkg::JOB_CIRCLE: begin
                            n_state = ST_SWEEP;
                        end
                        sfr_pkg::JOB_READ: begin
                            n_state = i_job.rd_out ? ST_DONE : ST_READ;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                if (r_addr == sfr_pkg::ADDR_W'(sfr_pkg::DEPTH - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_SWEEP: begin
                if (last_col && last_row) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_state = ST_DONE;
            end
            ST_READ: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_addr      <= '0;
            r_row_base  <= '0;
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= (r_state == ST_SWEEP);

            if (s2_write && (r_count != sfr_pkg::CNT_W'(sfr_pkg::COUNT_MAX))) begin
                r_count <= r_count + 1'b1;
            end

            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_col      <= '0;
                        r_row      <= '0;
                        r_addr     <= '0;
                        r_row_base <= '0;
                        r_count    <= (i_job.kind == sfr_pkg::JOB_CLEAR) ? i_job.area : '0;
                    end
                end
                ST_FILL: begin
                    r_addr <= r_addr + 1'b1;
                end
                ST_SWEEP: begin
                    if (last_col) begin
                        r_col <= '0;
                        if (!last_row) begin
                            r_row      <= r_row + 1'b1;
                            r_addr     <= r_row_base + sfr_pkg::ADDR_W'(sfr_pkg::MAX_WIDTH);
                            r_row_base <= r_row_base + sfr_pkg::ADDR_W'(sfr_pkg::MAX_WIDTH);
                        end
                    end else begin
                        r_col  <= r_col + 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (r_state == ST_DONE) begin
                r_res_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == ST_DONE) begin
            r_res_cell  <= ((r_job.kind == sfr_pkg::JOB_READ) && !r_job.rd_out) ?
                           r_rd_data : '0;
            r_res_count <= r_count;
            r_res_out   <= (r_job.kind == sfr_pkg::JOB_READ) && r_job.rd_out;
        end
    end

    assign o_pop  = (r_state == ST_IDLE) && !r_res_valid && !i_q.empty;
    assign o_busy = (r_state != ST_IDLE);

    assign o_res.valid         = r_res_valid;
    assign o_res.cell_symbol   = r_res_cell;
    assign o_res.cells_written = r_res_count;
    assign o_res.outside       = r_res_out;

endmodule

// ===== hdl/shape_fill_rasterizer.sv =====
// A clear sweeps all 64 by 64 cells of the store; a shape sweeps the W by H canvas in use;
// a read inside the canvas reads its one cell; an outside read, an unused code or a shape on
// an empty canvas goes straight to its result.
// The engine takes one command at a time; the next starts only after the result beat is taken.
// Reset: synchronous, active low; canvas registers go to 64, the store is undefined.
// ----------------------------------------------------------------------------
// Shape fill rasterizer
// Character frame buffer with a fill engine for clear, rectangle, triangle,
// circle and cell read commands, one result per command.
// ----------------------------------------------------------------------------
module shape_fill_rasterizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sfr_cmd_if.sink                       i_cmd,
    sfr_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sfr_pkg::CFG_W-1:0]     i_cfg_data
);

    sfr_pkg::t_job      push_job;
    sfr_pkg::t_job      head_job;
    sfr_pkg::t_q_status q_status;
    logic               push;
    logic               pop;
    logic               busy;

    sfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q        (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    sfr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    sfr_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (head_job),
        .i_q     (q_status),
        .o_pop   (pop),
        .o_busy  (busy),
        .o_res   (o_res)
    );

`ifndef SYNTHESIS
    a_push_fills_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> !q_status.empty)
        else $error("queue empty after a beat was accepted");

    a_result_waits_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !busy)
        else $error("engine busy while a result is pending");

    a_outside_is_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.outside) |->
            (o_res.cells_written == '0 && o_res.cell_symbol == '0))
        else $error("outside read carries data");
`endif

endmodule
